### sv/dllc_pkg.sv
// Shared definitions for the linked list core: command codes, error codes,
// sequencer states and default sizes. No dependencies.
package dllc_pkg;

  localparam int unsigned PoolNodesDefault = 256;
  localparam int unsigned ValueBitsDefault = 32;

  localparam int unsigned CmdW = 5;
  localparam int unsigned ErrW = 2;

  localparam logic [CmdW-1:0] CMD_CLEAR      = 5'd0;
  localparam logic [CmdW-1:0] CMD_INS_HEAD   = 5'd1;
  localparam logic [CmdW-1:0] CMD_INS_TAIL   = 5'd2;
  localparam logic [CmdW-1:0] CMD_CUR_HEAD   = 5'd3;
  localparam logic [CmdW-1:0] CMD_CUR_TAIL   = 5'd4;
  localparam logic [CmdW-1:0] CMD_RD_HEAD    = 5'd5;
  localparam logic [CmdW-1:0] CMD_RD_TAIL    = 5'd6;
  localparam logic [CmdW-1:0] CMD_DEL_HEAD   = 5'd7;
  localparam logic [CmdW-1:0] CMD_DEL_TAIL   = 5'd8;
  localparam logic [CmdW-1:0] CMD_DEL_AFTER  = 5'd9;
  localparam logic [CmdW-1:0] CMD_DEL_BEFORE = 5'd10;
  localparam logic [CmdW-1:0] CMD_INS_AFTER  = 5'd11;
  localparam logic [CmdW-1:0] CMD_INS_BEFORE = 5'd12;
  localparam logic [CmdW-1:0] CMD_RD_CUR     = 5'd13;
  localparam logic [CmdW-1:0] CMD_WR_CUR     = 5'd14;
  localparam logic [CmdW-1:0] CMD_NEXT       = 5'd15;
  localparam logic [CmdW-1:0] CMD_PREV       = 5'd16;
  localparam logic [CmdW-1:0] CMD_QUERY      = 5'd17;

  localparam logic [ErrW-1:0] ERR_OK    = 2'd0;
  localparam logic [ErrW-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ErrW-1:0] ERR_FULL  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD1  = 5'b00010,
    ST_RD2  = 5'b00100,
    ST_WR2  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

endpackage

### sv/dllc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dllc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/doubly_linked_list_with_cursor_core.sv
// Top level of the linked list core: command sequencer, list registers and
// the four pool memories. Depends on dllc_pkg and dllc_ram.

// The core keeps a doubly linked list of signed values in a pool of
// POOL_NODES nodes, with head, tail and cursor pointers, and executes one
// command word at a time. Each command runs through the sequencer states
// from acceptance to its result word: the cycle that accepts it issues the
// first reads of the link, value and free-stack memories, RD1 issues a
// dependent link read (a neighbor of a neighbor), then RD2 and WR2 write the
// link memories, since a command may update two entries of the same memory
// and each memory has one write port; OUT presents the result. The result
// sits in an output register, so a new command is accepted while it waits; a
// second result waits in OUT until the first has been taken. The pool
// memories need no clearing: an allocation high-water mark and a free stack
// make sure only written entries are ever read, so clear takes effect at once.
module doubly_linked_list_with_cursor_core #(
  parameter int unsigned POOL_NODES = dllc_pkg::PoolNodesDefault,
  parameter int unsigned VALUE_BITS = dllc_pkg::ValueBitsDefault,
  localparam int unsigned InW  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((VALUE_BITS + 5 + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // tdata: value
  input  logic [InW-1:0]           s_axis_tdata_i,
  // tuser: cmd
  input  logic [dllc_pkg::CmdW-1:0] s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // tdata: read_value, read_valid, error_code, cursor_active, list_empty
  output logic [OutW-1:0]          m_axis_tdata_o
);

  localparam int unsigned IdxW = $clog2(POOL_NODES);
  localparam int unsigned PtrW = IdxW + 1;
  localparam logic [PtrW-1:0] Nil = PtrW'(POOL_NODES);

  dllc_pkg::state_e state_q, state_d;

  logic [dllc_pkg::CmdW-1:0] cmd_q;
  logic [VALUE_BITS-1:0]     val_q;
  logic [PtrW-1:0] head_q, tail_q, cur_q, ftop_q, hw_q;
  logic [PtrW-1:0] nx_q, pv_q;

  logic [VALUE_BITS-1:0]     res_rd_q;
  logic                      res_valid_q;
  logic [dllc_pkg::ErrW-1:0] res_err_q;

  logic                      out_valid_q;
  logic [OutW-1:0]           out_data_q;

  // Memory ports.
  logic                  va_we, va_re;
  logic [IdxW-1:0]       va_waddr, va_raddr;
  logic [VALUE_BITS-1:0] va_wdata, va_rdata;
  logic                  nx_we, nx_re;
  logic [IdxW-1:0]       nx_waddr, nx_raddr;
  logic [PtrW-1:0]       nx_wdata, nx_rdata;
  logic                  pv_we, pv_re;
  logic [IdxW-1:0]       pv_waddr, pv_raddr;
  logic [PtrW-1:0]       pv_wdata, pv_rdata;
  logic                  fs_we, fs_re;
  logic [IdxW-1:0]       fs_waddr, fs_raddr;
  logic [IdxW-1:0]       fs_wdata, fs_rdata;

  // Plan of the command being executed: first write set, second write set
  // and the register updates. Inputs to it stay put through RD2 and WR2.
  logic                  a_va_we, a_nx_we, a_pv_we, a_fs_we;
  logic [PtrW-1:0]       a_va_addr, a_nx_addr, a_pv_addr, a_fs_data;
  logic [PtrW-1:0]       a_nx_data, a_pv_data;
  logic                  b_nx_we, b_pv_we;
  logic [PtrW-1:0]       b_nx_addr, b_pv_addr, b_nx_data, b_pv_data;
  logic [PtrW-1:0]       head_n, tail_n, cur_n, ftop_n, hw_n;
  logic [dllc_pkg::ErrW-1:0] err_n;
  logic                  rdv_n;

  logic            pop, alloc_ok;
  logic [PtrW-1:0] new_node;
  logic            give_ok;

  logic accept;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == dllc_pkg::ST_IDLE);

  assign pop      = (ftop_q != '0);
  assign new_node = pop ? {1'b0, fs_rdata} : hw_q;
  assign alloc_ok = pop || (hw_q < Nil);
  assign give_ok  = (ftop_q < Nil);

  always_comb begin
    a_va_we = 1'b0; a_nx_we = 1'b0; a_pv_we = 1'b0; a_fs_we = 1'b0;
    a_va_addr = cur_q; a_nx_addr = cur_q; a_pv_addr = cur_q; a_fs_data = nx_q;
    a_nx_data = Nil; a_pv_data = Nil;
    b_nx_we = 1'b0; b_pv_we = 1'b0;
    b_nx_addr = cur_q; b_pv_addr = cur_q; b_nx_data = Nil; b_pv_data = Nil;
    head_n = head_q; tail_n = tail_q; cur_n = cur_q;
    ftop_n = ftop_q; hw_n = hw_q;
    err_n = dllc_pkg::ERR_OK;
    rdv_n = 1'b0;
    unique case (cmd_q)
      dllc_pkg::CMD_CLEAR: begin
        ftop_n = '0; hw_n = '0;
        head_n = Nil; tail_n = Nil; cur_n = Nil;
      end
      dllc_pkg::CMD_INS_HEAD, dllc_pkg::CMD_INS_TAIL,
      dllc_pkg::CMD_INS_AFTER, dllc_pkg::CMD_INS_BEFORE: begin
        if ((cmd_q == dllc_pkg::CMD_INS_AFTER || cmd_q == dllc_pkg::CMD_INS_BEFORE)
            && cur_q == Nil) begin
          // Inactive cursor: nothing happens, the pool is not tested.
        end else if (!alloc_ok) begin
          err_n = dllc_pkg::ERR_FULL;
        end else begin
          if (pop) ftop_n = ftop_q - 1'b1;
          else     hw_n   = hw_q + 1'b1;
          a_va_we = 1'b1; a_va_addr = new_node;
          a_nx_we = 1'b1; a_nx_addr = new_node;
          a_pv_we = 1'b1; a_pv_addr = new_node;
          unique case (cmd_q)
            dllc_pkg::CMD_INS_HEAD: begin
              a_nx_data = head_q; a_pv_data = Nil;
              b_pv_we = (head_q != Nil); b_pv_addr = head_q; b_pv_data = new_node;
              if (head_q == Nil) tail_n = new_node;
              head_n = new_node;
            end
            dllc_pkg::CMD_INS_TAIL: begin
              a_pv_data = tail_q; a_nx_data = Nil;
              b_nx_we = (tail_q != Nil); b_nx_addr = tail_q; b_nx_data = new_node;
              if (tail_q == Nil) head_n = new_node;
              tail_n = new_node;
            end
            dllc_pkg::CMD_INS_AFTER: begin
              a_pv_data = cur_q; a_nx_data = nx_q;
              b_nx_we = 1'b1; b_nx_addr = cur_q; b_nx_data = new_node;
              if (cur_q == tail_q) tail_n = new_node;
              else begin
                b_pv_we = 1'b1; b_pv_addr = nx_q; b_pv_data = new_node;
              end
            end
            default: begin
              a_pv_data = pv_q; a_nx_data = cur_q;
              b_pv_we = 1'b1; b_pv_addr = cur_q; b_pv_data = new_node;
              if (cur_q == head_q) head_n = new_node;
              else begin
                b_nx_we = 1'b1; b_nx_addr = pv_q; b_nx_data = new_node;
              end
            end
          endcase
        end
      end
      dllc_pkg::CMD_CUR_HEAD: cur_n = head_q;
      dllc_pkg::CMD_CUR_TAIL: cur_n = tail_q;
      dllc_pkg::CMD_RD_HEAD: begin
        if (head_q == Nil) err_n = dllc_pkg::ERR_EMPTY;
        else rdv_n = 1'b1;
      end
      dllc_pkg::CMD_RD_TAIL: begin
        if (tail_q == Nil) err_n = dllc_pkg::ERR_EMPTY;
        else rdv_n = 1'b1;
      end
      dllc_pkg::CMD_RD_CUR: begin
        if (cur_q == Nil) err_n = dllc_pkg::ERR_EMPTY;
        else rdv_n = 1'b1;
      end
      dllc_pkg::CMD_DEL_HEAD: begin
        if (head_q != Nil) begin
          if (head_q == cur_q) cur_n = Nil;
          if (head_q == tail_q) begin
            head_n = Nil; tail_n = Nil;
          end else begin
            head_n = nx_q;
            b_pv_we = 1'b1; b_pv_addr = nx_q; b_pv_data = Nil;
          end
          a_fs_we = give_ok; a_fs_data = head_q;
          if (give_ok) ftop_n = ftop_q + 1'b1;
        end
      end
      dllc_pkg::CMD_DEL_TAIL: begin
        if (tail_q != Nil) begin
          if (tail_q == cur_q) cur_n = Nil;
          if (tail_q == head_q) begin
            head_n = Nil; tail_n = Nil;
          end else begin
            tail_n = pv_q;
            b_nx_we = 1'b1; b_nx_addr = pv_q; b_nx_data = Nil;
          end
          a_fs_we = give_ok; a_fs_data = tail_q;
          if (give_ok) ftop_n = ftop_q + 1'b1;
        end
      end
      dllc_pkg::CMD_DEL_AFTER: begin
        // The victim is next of cursor; nx_rdata holds the victim's next.
        if (cur_q != Nil && cur_q != tail_q) begin
          a_nx_we = 1'b1; a_nx_addr = cur_q; a_nx_data = nx_rdata;
          if (nx_q == tail_q) tail_n = cur_q;
          else begin
            b_pv_we = 1'b1; b_pv_addr = nx_rdata; b_pv_data = cur_q;
          end
          a_fs_we = give_ok && (nx_q != Nil); a_fs_data = nx_q;
          if (give_ok && nx_q != Nil) ftop_n = ftop_q + 1'b1;
        end
      end
      dllc_pkg::CMD_DEL_BEFORE: begin
        if (cur_q != Nil && cur_q != head_q) begin
          a_pv_we = 1'b1; a_pv_addr = cur_q; a_pv_data = pv_rdata;
          if (pv_q == head_q) head_n = cur_q;
          else begin
            b_nx_we = 1'b1; b_nx_addr = pv_rdata; b_nx_data = cur_q;
          end
          a_fs_we = give_ok && (pv_q != Nil); a_fs_data = pv_q;
          if (give_ok && pv_q != Nil) ftop_n = ftop_q + 1'b1;
        end
      end
      dllc_pkg::CMD_WR_CUR: begin
        a_va_we = (cur_q != Nil); a_va_addr = cur_q;
      end
      dllc_pkg::CMD_NEXT: if (cur_q != Nil) cur_n = nx_q;
      dllc_pkg::CMD_PREV: if (cur_q != Nil) cur_n = pv_q;
      default: ;
    endcase
  end

  // Read side: first reads at acceptance, dependent link reads in RD1.
  always_comb begin
    va_re = accept; nx_re = 1'b0; pv_re = 1'b0; fs_re = accept;
    va_raddr = cur_q[IdxW-1:0];
    nx_raddr = cur_q[IdxW-1:0];
    pv_raddr = cur_q[IdxW-1:0];
    fs_raddr = IdxW'(ftop_q - 1'b1);
    if (accept) begin
      nx_re = 1'b1; pv_re = 1'b1;
      unique case (s_axis_tuser_i)
        dllc_pkg::CMD_RD_HEAD: va_raddr = head_q[IdxW-1:0];
        dllc_pkg::CMD_RD_TAIL: va_raddr = tail_q[IdxW-1:0];
        dllc_pkg::CMD_DEL_HEAD: nx_raddr = head_q[IdxW-1:0];
        dllc_pkg::CMD_DEL_TAIL: pv_raddr = tail_q[IdxW-1:0];
        default: ;
      endcase
    end else if (state_q == dllc_pkg::ST_RD1) begin
      nx_re = 1'b1; pv_re = 1'b1;
      nx_raddr = nx_rdata[IdxW-1:0];
      pv_raddr = pv_rdata[IdxW-1:0];
    end
  end

  // Write side: first set in RD2, second set in WR2.
  always_comb begin
    va_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; fs_we = 1'b0;
    va_waddr = a_va_addr[IdxW-1:0];
    va_wdata = val_q;
    fs_waddr = ftop_q[IdxW-1:0];
    fs_wdata = a_fs_data[IdxW-1:0];
    nx_waddr = a_nx_addr[IdxW-1:0]; nx_wdata = a_nx_data;
    pv_waddr = a_pv_addr[IdxW-1:0]; pv_wdata = a_pv_data;
    if (state_q == dllc_pkg::ST_RD2) begin
      va_we = a_va_we; nx_we = a_nx_we; pv_we = a_pv_we; fs_we = a_fs_we;
    end else if (state_q == dllc_pkg::ST_WR2) begin
      nx_we = b_nx_we; pv_we = b_pv_we;
      nx_waddr = b_nx_addr[IdxW-1:0]; nx_wdata = b_nx_data;
      pv_waddr = b_pv_addr[IdxW-1:0]; pv_wdata = b_pv_data;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dllc_pkg::ST_IDLE: if (accept) state_d = dllc_pkg::ST_RD1;
      dllc_pkg::ST_RD1:  state_d = dllc_pkg::ST_RD2;
      dllc_pkg::ST_RD2:  state_d = dllc_pkg::ST_WR2;
      dllc_pkg::ST_WR2:  state_d = dllc_pkg::ST_OUT;
      dllc_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) state_d = dllc_pkg::ST_IDLE;
      end
      default: state_d = dllc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dllc_pkg::ST_IDLE;
      head_q      <= Nil;
      tail_q      <= Nil;
      cur_q       <= Nil;
      ftop_q      <= '0;
      hw_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dllc_pkg::ST_WR2) begin
        head_q <= head_n;
        tail_q <= tail_n;
        cur_q  <= cur_n;
        ftop_q <= ftop_n;
        hw_q   <= hw_n;
      end
      if (state_q == dllc_pkg::ST_OUT && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tuser_i;
      val_q <= s_axis_tdata_i[VALUE_BITS-1:0];
    end
    if (state_q == dllc_pkg::ST_RD1) begin
      nx_q <= nx_rdata;
      pv_q <= pv_rdata;
    end
    if (state_q == dllc_pkg::ST_WR2) begin
      res_rd_q    <= rdv_n ? va_rdata : '0;
      res_valid_q <= rdv_n;
      res_err_q   <= err_n;
    end
    if (state_q == dllc_pkg::ST_OUT && (!out_valid_q || m_axis_tready_i)) begin
      out_data_q <= OutW'({(head_q == Nil), (cur_q != Nil), res_err_q,
                           res_valid_q, res_rd_q});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  dllc_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_value_ram (
    .clk_i, .we_i(va_we), .waddr_i(va_waddr), .wdata_i(va_wdata),
    .re_i(va_re), .raddr_i(va_raddr), .rdata_o(va_rdata)
  );

  dllc_ram #(.WIDTH(PtrW), .DEPTH(POOL_NODES)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .re_i(nx_re), .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );

  dllc_ram #(.WIDTH(PtrW), .DEPTH(POOL_NODES)) u_prev_ram (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .re_i(pv_re), .raddr_i(pv_raddr), .rdata_o(pv_rdata)
  );

  dllc_ram #(.WIDTH(IdxW), .DEPTH(POOL_NODES)) u_free_ram (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .re_i(fs_re), .raddr_i(fs_raddr), .rdata_o(fs_rdata)
  );

endmodule

### verif/doubly_linked_list_with_cursor_core_test.sv
// Self-checking testbench for the linked list core: drives command words,
// predicts every result word with a behavioral list model and compares them.
// Depends on dllc_pkg and doubly_linked_list_with_cursor_core.
module doubly_linked_list_with_cursor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Nodes = dllc_pkg::PoolNodesDefault;
  localparam int unsigned Nil = Nodes;
  localparam int unsigned CycleLimit = 400000;

  // Packed from the top bit down, so the last member sits in the lowest bits.
  typedef struct packed {
    logic                        is_empty;
    logic                        cur_on;
    logic [dllc_pkg::ErrW-1:0]   err;
    logic                        rd_ok;
    logic signed [31:0]          rd_val;
  } status_t;

  // Behavioral list with its own copy of the pool, and the queue of expected
  // status words.
  class list_scoreboard;
    logic [31:0] val_mem [Nodes+1];
    int unsigned nxt [Nodes+1];
    int unsigned prv [Nodes+1];
    int unsigned free_q [Nodes+1];
    int unsigned free_cnt, hwm, head, tail, cur;
    status_t pending [$];
    int errors;

    function void clear_pool();
      free_cnt = 0; hwm = 0; head = Nil; tail = Nil; cur = Nil;
    endfunction

    function int unsigned grab();
      if (free_cnt > 0) begin
        free_cnt--;
        return free_q[free_cnt];
      end
      if (hwm < Nodes) begin
        hwm++;
        return hwm - 1;
      end
      return Nil;
    endfunction

    function void give(int unsigned n);
      if (free_cnt < Nodes && n < Nil) begin
        free_q[free_cnt] = n;
        free_cnt++;
      end
    endfunction

    function int unsigned depth();
      return hwm - free_cnt;
    endfunction

    // Notes one accepted command word and queues its expected status.
    function void note_command(logic [dllc_pkg::CmdW-1:0] op, logic [31:0] v);
      status_t s;
      int unsigned n, w, c;
      s = '0;
      c = cur;
      case (op)
        dllc_pkg::CMD_CLEAR: clear_pool();
        dllc_pkg::CMD_INS_HEAD: begin
          n = grab();
          if (n == Nil) s.err = dllc_pkg::ERR_FULL;
          else begin
            val_mem[n] = v; nxt[n] = head; prv[n] = Nil;
            if (head != Nil) prv[head] = n; else tail = n;
            head = n;
          end
        end
        dllc_pkg::CMD_INS_TAIL: begin
          n = grab();
          if (n == Nil) s.err = dllc_pkg::ERR_FULL;
          else begin
            val_mem[n] = v; prv[n] = tail; nxt[n] = Nil;
            if (tail != Nil) nxt[tail] = n; else head = n;
            tail = n;
          end
        end
        dllc_pkg::CMD_CUR_HEAD: cur = head;
        dllc_pkg::CMD_CUR_TAIL: cur = tail;
        dllc_pkg::CMD_RD_HEAD, dllc_pkg::CMD_RD_TAIL: begin
          n = (op == dllc_pkg::CMD_RD_HEAD) ? head : tail;
          if (n == Nil) s.err = dllc_pkg::ERR_EMPTY;
          else begin
            s.rd_val = val_mem[n]; s.rd_ok = 1'b1;
          end
        end
        dllc_pkg::CMD_DEL_HEAD: if (head != Nil) begin
          n = head;
          if (n == cur) cur = Nil;
          if (n == tail) begin
            head = Nil; tail = Nil;
          end else begin
            head = nxt[n]; prv[head] = Nil;
          end
          give(n);
        end
        dllc_pkg::CMD_DEL_TAIL: if (tail != Nil) begin
          n = tail;
          if (n == cur) cur = Nil;
          if (n == head) begin
            head = Nil; tail = Nil;
          end else begin
            tail = prv[n]; nxt[tail] = Nil;
          end
          give(n);
        end
        dllc_pkg::CMD_DEL_AFTER: if (c != Nil && c != tail) begin
          w = nxt[c];
          nxt[c] = nxt[w];
          if (w == tail) tail = c; else prv[nxt[w]] = c;
          give(w);
        end
        dllc_pkg::CMD_DEL_BEFORE: if (c != Nil && c != head) begin
          w = prv[c];
          prv[c] = prv[w];
          if (w == head) head = c; else nxt[prv[w]] = c;
          give(w);
        end
        dllc_pkg::CMD_INS_AFTER: if (c != Nil) begin
          n = grab();
          if (n == Nil) s.err = dllc_pkg::ERR_FULL;
          else begin
            val_mem[n] = v; prv[n] = c; nxt[n] = nxt[c];
            if (c == tail) tail = n; else prv[nxt[c]] = n;
            nxt[c] = n;
          end
        end
        dllc_pkg::CMD_INS_BEFORE: if (c != Nil) begin
          n = grab();
          if (n == Nil) s.err = dllc_pkg::ERR_FULL;
          else begin
            val_mem[n] = v; prv[n] = prv[c]; nxt[n] = c;
            if (c == head) head = n; else nxt[prv[c]] = n;
            prv[c] = n;
          end
        end
        dllc_pkg::CMD_RD_CUR: begin
          if (c == Nil) s.err = dllc_pkg::ERR_EMPTY;
          else begin
            s.rd_val = val_mem[c]; s.rd_ok = 1'b1;
          end
        end
        dllc_pkg::CMD_WR_CUR: if (c != Nil) val_mem[c] = v;
        dllc_pkg::CMD_NEXT: if (c != Nil) cur = nxt[c];
        dllc_pkg::CMD_PREV: if (c != Nil) cur = prv[c];
        default: ;
      endcase
      s.cur_on = (cur != Nil);
      s.is_empty = (head == Nil);
      pending.push_back(s);
    endfunction

    // Compares one result word with the oldest expectation.
    function void check_result(logic [39:0] word);
      status_t got, want;
      got = word[36:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, word);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.rd_val !== want.rd_val) begin
        $display("%0t: read_value expected %0d actual %0d", $time, want.rd_val, got.rd_val);
        errors++;
      end
      if (got.rd_ok !== want.rd_ok) begin
        $display("%0t: read_valid expected %b actual %b", $time, want.rd_ok, got.rd_ok);
        errors++;
      end
      if (got.err !== want.err) begin
        $display("%0t: error_code expected %0d actual %0d", $time, want.err, got.err);
        errors++;
      end
      if (got.cur_on !== want.cur_on) begin
        $display("%0t: cursor_active expected %b actual %b", $time, want.cur_on,
                 got.cur_on);
        errors++;
      end
      if (got.is_empty !== want.is_empty) begin
        $display("%0t: list_empty expected %b actual %b", $time, want.is_empty,
                 got.is_empty);
        errors++;
      end
      if (word[39:37] !== 3'b000) begin
        $display("%0t: pad bits expected 0 actual %b", $time, word[39:37]);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid_i;
  logic                      s_axis_tready_o;
  // tdata: value
  logic [31:0]               s_axis_tdata_i;
  // tuser: cmd
  logic [dllc_pkg::CmdW-1:0] s_axis_tuser_i;
  logic                      m_axis_tvalid_o;
  logic                      m_axis_tready_i;
  // tdata: read_value, read_valid, error_code, cursor_active, list_empty
  logic [39:0]               m_axis_tdata_o;

  list_scoreboard sb;
  bit             quiet;    // suppresses idling on both sides
  int             cycles;

  doubly_linked_list_with_cursor_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls at random, except during quiet stretches.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= quiet || ($urandom_range(99) >= 9);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sends one command word; the model is updated at the accepting edge. The
  // valid stays up afterwards so that the next word can follow at once.
  task automatic send(logic [dllc_pkg::CmdW-1:0] op, logic [31:0] v);
    while (!quiet && $urandom_range(99) < 9) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= v;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(op, v);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly list-shaped traffic: inserts while short, cursor walks and edits.
  function automatic logic [dllc_pkg::CmdW-1:0] rand_op(bit grow);
    int r;
    r = $urandom_range(99);
    if (r < 2) return dllc_pkg::CmdW'($urandom_range(18, 31));
    if (r < 3) return dllc_pkg::CMD_CLEAR;
    if (grow && r < 45) begin
      return logic'($urandom_range(1)) ? dllc_pkg::CMD_INS_HEAD : dllc_pkg::CMD_INS_TAIL;
    end
    if (r < 55) begin
      return logic'($urandom_range(1)) ? dllc_pkg::CMD_INS_AFTER : dllc_pkg::CMD_INS_BEFORE;
    end
    return dllc_pkg::CmdW'($urandom_range(1, 17));
  endfunction

  initial begin
    logic [dllc_pkg::CmdW-1:0] op;
    bit grow;
    sb = new();
    sb.clear_pool();
    quiet = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list reads and deletes, inactive cursor, edges, cursor
    // removal, value extremes, with every operation at least once and unused codes.
    send(dllc_pkg::CMD_RD_HEAD, 0);
    send(dllc_pkg::CMD_RD_TAIL, 0);
    send(dllc_pkg::CMD_DEL_HEAD, 0);
    send(dllc_pkg::CMD_DEL_TAIL, 0);
    send(dllc_pkg::CMD_RD_CUR, 0);
    send(dllc_pkg::CMD_INS_AFTER, 1);
    send(dllc_pkg::CMD_INS_BEFORE, 1);
    send(dllc_pkg::CMD_INS_HEAD, 32'h7fff_ffff);
    send(dllc_pkg::CMD_INS_TAIL, 32'h8000_0000);
    send(dllc_pkg::CMD_CUR_HEAD, 0);
    send(dllc_pkg::CMD_PREV, 0);
    send(dllc_pkg::CMD_QUERY, 0);
    send(dllc_pkg::CMD_CUR_TAIL, 0);
    send(dllc_pkg::CMD_DEL_AFTER, 0);
    send(dllc_pkg::CMD_INS_BEFORE, 32'hffff_ffff);
    send(dllc_pkg::CMD_DEL_BEFORE, 0);
    send(dllc_pkg::CMD_WR_CUR, 32'h5555_aaaa);
    send(dllc_pkg::CMD_RD_CUR, 0);
    send(dllc_pkg::CMD_NEXT, 0);
    send(dllc_pkg::CMD_CUR_TAIL, 0);
    send(dllc_pkg::CMD_DEL_TAIL, 0);
    send(dllc_pkg::CMD_RD_HEAD, 0);
    send(dllc_pkg::CmdW'(31), 0);
    send(dllc_pkg::CmdW'(18), 0);
    send(dllc_pkg::CMD_CLEAR, 0);

    // Fill the pool to its end, overflow it, free some and reuse them.
    quiet = 1'b1;
    for (int i = 0; i < Nodes + 2; i++) send(dllc_pkg::CMD_INS_TAIL, $urandom);
    send(dllc_pkg::CMD_CUR_HEAD, 0);
    send(dllc_pkg::CMD_INS_AFTER, 0);
    for (int i = 0; i < 5; i++) send(dllc_pkg::CMD_DEL_HEAD, 0);
    send(dllc_pkg::CMD_NEXT, 0);
    for (int i = 0; i < 7; i++) send(dllc_pkg::CMD_INS_HEAD, $urandom);
    quiet = 1'b0;
    drain();
    send(dllc_pkg::CMD_CLEAR, 0);

    for (int i = 0; i < 750; i++) begin
      grow = sb.depth() < 12;
      op = rand_op(grow);
      if (i % 300 == 150) quiet = 1'b1;
      if (i % 300 == 250) quiet = 1'b0;
      if (i == 500) drain();
      send(op, rand_value());
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
